### hdl/assert_macros.svh
// Assertion macros used by the checker file of the face normal block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TNA_ASSERT(name, clk_s, rstn_s, prop) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("assertion failed: %m");

// Clocked assertion that is also checked during reset.
`define TNA_ASSERT_ALWAYS(name, clk_s, prop) \
	name: assert property (@(posedge clk_s) (prop)) \
		else $error("assertion failed: %m");

`endif

### hdl/tna_pkg.sv
// Shared constants, types and state codes of the triangle normal/area block.
// No dependencies.
`default_nettype none

package tna_pkg;

	localparam int VERTEX_COUNT = 4096;
	localparam int ADDR_W       = $clog2(VERTEX_COUNT);

	localparam int IDX_W   = 12;
	localparam int COORD_W = 24;
	localparam int VERT_W  = 3 * COORD_W;
	localparam int NORM_W  = 32;
	localparam int AREA_W  = 53;

	localparam int EDGE_W  = COORD_W + 1;
	localparam int MOP_W   = 27;
	localparam int PROD_W  = 2 * MOP_W;
	localparam int CROSS_W = 51;
	localparam int LO_W    = 26;
	localparam int SUM_W   = 104;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int QUO_W   = 32;

	localparam int HH_SHIFT = 2 * LO_W;
	localparam int HL_SHIFT = LO_W + 1;

	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] CROSS_LAST = CNT_W'(6);
	localparam logic [CNT_W-1:0] SQ_LAST    = CNT_W'(9);
	localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(ROOT_W);
	localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W + 1);
	localparam logic [1:0]       COMP_LAST  = 2'd2;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_FACE = 1'b1
	} tna_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_B,
		ST_RD_C,
		ST_EDGE,
		ST_CROSS,
		ST_SQUARE,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} tna_state_t;

	// partial products of one squared cross component
	typedef enum logic [1:0] {
		TERM_HH,
		TERM_LL,
		TERM_HL
	} tna_term_t;

	typedef struct packed {
		logic [1:0] comp;
		tna_term_t  term;
	} tna_sq_sel_t;

	typedef struct packed {
		logic             accept;
		logic             ld_v0;
		logic             ld_v1;
		logic             ld_edge;
		logic             cross_en;
		logic             square_en;
		logic             sqrt_en;
		logic             div_en;
		logic             out_load;
		logic [CNT_W-1:0] step;
		logic [1:0]       comp;
	} tna_cmd_t;

	typedef struct packed {
		logic is_face;
		logic face_ok;
	} tna_status_t;

endpackage

`default_nettype wire

### hdl/tna_if.sv
// Request and result channel interfaces of the triangle normal/area block.
// Depends on tna_pkg.
`default_nettype none

interface tna_item_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [tna_pkg::IDX_W-1:0]           vert_index;
	logic signed [tna_pkg::COORD_W-1:0]  coord_x;
	logic signed [tna_pkg::COORD_W-1:0]  coord_y;
	logic signed [tna_pkg::COORD_W-1:0]  coord_z;
	logic [tna_pkg::IDX_W-1:0]           corner_a;
	logic [tna_pkg::IDX_W-1:0]           corner_b;
	logic [tna_pkg::IDX_W-1:0]           corner_c;

	modport source (output valid, op, vert_index, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, op, vert_index, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface tna_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [tna_pkg::NORM_W-1:0]  normal_x;
	logic signed [tna_pkg::NORM_W-1:0]  normal_y;
	logic signed [tna_pkg::NORM_W-1:0]  normal_z;
	logic [tna_pkg::AREA_W-1:0]         face_area_out;
	logic                               degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, face_area_out,
		degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, face_area_out,
		degenerate, output ready);
endinterface

`default_nettype wire

### hdl/tna_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

### hdl/tna_ctrl.sv
// Sequencer of the triangle normal/area block: steps one face through
// store reads, cross product, sum of squares, square root and divisions. Uses tna_pkg.
`default_nettype none

module tna_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire tna_pkg::tna_status_t status,
	output tna_pkg::tna_cmd_t         cmd
);

	tna_pkg::tna_state_t            state_q, state_d;
	logic [tna_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [1:0]                     comp_q, comp_d;
	logic                           out_valid_q;
	logic                           accept;
	logic                           out_free;

	assign in_ready  = (state_q == tna_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		comp_d  = comp_q;
		case (state_q)
			tna_pkg::ST_IDLE: begin
				if (accept && status.is_face && status.face_ok) begin
					state_d = tna_pkg::ST_RD_B;
				end
			end
			tna_pkg::ST_RD_B: state_d = tna_pkg::ST_RD_C;
			tna_pkg::ST_RD_C: state_d = tna_pkg::ST_EDGE;
			tna_pkg::ST_EDGE: begin
				state_d = tna_pkg::ST_CROSS;
				cnt_d   = '0;
			end
			tna_pkg::ST_CROSS: begin
				if (cnt_q == tna_pkg::CROSS_LAST) begin
					state_d = tna_pkg::ST_SQUARE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tna_pkg::ST_SQUARE: begin
				if (cnt_q == tna_pkg::SQ_LAST) begin
					state_d = tna_pkg::ST_SQRT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tna_pkg::ST_SQRT: begin
				if (cnt_q == tna_pkg::SQRT_LAST) begin
					state_d = tna_pkg::ST_DIV;
					cnt_d   = '0;
					comp_d  = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tna_pkg::ST_DIV: begin
				if (cnt_q == tna_pkg::DIV_LAST) begin
					cnt_d = '0;
					if (comp_q == tna_pkg::COMP_LAST) begin
						state_d = tna_pkg::ST_OUT;
					end else begin
						comp_d = comp_q + 1'b1;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tna_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = tna_pkg::ST_IDLE;
				end
			end
			default: state_d = tna_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.step      = cnt_q;
		cmd.comp      = comp_q;
		cmd.ld_v0     = (state_q == tna_pkg::ST_RD_B);
		cmd.ld_v1     = (state_q == tna_pkg::ST_RD_C);
		cmd.ld_edge   = (state_q == tna_pkg::ST_EDGE);
		cmd.cross_en  = (state_q == tna_pkg::ST_CROSS);
		cmd.square_en = (state_q == tna_pkg::ST_SQUARE);
		cmd.sqrt_en   = (state_q == tna_pkg::ST_SQRT);
		cmd.div_en    = (state_q == tna_pkg::ST_DIV);
		cmd.out_load  = (state_q == tna_pkg::ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tna_pkg::ST_IDLE;
			cnt_q       <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/tna_datapath.sv
// Datapath of the triangle normal/area block: vertex store, shared multiplier,
// square root and divide iterations, result register. Uses tna_pkg and tna_ram.
`default_nettype none

module tna_datapath (
	input  wire logic                                  clk,
	input  wire tna_pkg::tna_cmd_t                     cmd,
	output tna_pkg::tna_status_t                       status,
	input  wire logic                                  op,
	input  wire logic [tna_pkg::IDX_W-1:0]             vert_index,
	input  wire logic signed [tna_pkg::COORD_W-1:0]    coord_x,
	input  wire logic signed [tna_pkg::COORD_W-1:0]    coord_y,
	input  wire logic signed [tna_pkg::COORD_W-1:0]    coord_z,
	input  wire logic [tna_pkg::IDX_W-1:0]             corner_a,
	input  wire logic [tna_pkg::IDX_W-1:0]             corner_b,
	input  wire logic [tna_pkg::IDX_W-1:0]             corner_c,
	output logic signed [tna_pkg::NORM_W-1:0]          normal_x,
	output logic signed [tna_pkg::NORM_W-1:0]          normal_y,
	output logic signed [tna_pkg::NORM_W-1:0]          normal_z,
	output logic [tna_pkg::AREA_W-1:0]                 face_area_out,
	output logic                                       degenerate
);

	function automatic tna_pkg::tna_sq_sel_t sq_map(input logic [3:0] i);
		tna_pkg::tna_sq_sel_t r;
		r.comp = '0;
		r.term = tna_pkg::TERM_HH;
		case (i)
			4'd0: r = '{2'd0, tna_pkg::TERM_HH};
			4'd1: r = '{2'd0, tna_pkg::TERM_LL};
			4'd2: r = '{2'd0, tna_pkg::TERM_HL};
			4'd3: r = '{2'd1, tna_pkg::TERM_HH};
			4'd4: r = '{2'd1, tna_pkg::TERM_LL};
			4'd5: r = '{2'd1, tna_pkg::TERM_HL};
			4'd6: r = '{2'd2, tna_pkg::TERM_HH};
			4'd7: r = '{2'd2, tna_pkg::TERM_LL};
			4'd8: r = '{2'd2, tna_pkg::TERM_HL};
			default: r = '{2'd0, tna_pkg::TERM_HH};
		endcase
		return r;
	endfunction

	logic [tna_pkg::IDX_W-1:0]             corner_b_q, corner_c_q;
	logic [tna_pkg::ADDR_W-1:0]            rd_addr;
	logic [tna_pkg::VERT_W-1:0]            rd_data;
	logic                                  load_ok;
	logic                                  wr_en;

	logic signed [tna_pkg::COORD_W-1:0]    v0_q [3];
	logic signed [tna_pkg::COORD_W-1:0]    v1_q [3];
	logic signed [tna_pkg::COORD_W-1:0]    v2 [3];
	logic signed [tna_pkg::EDGE_W-1:0]     e1_q [3];
	logic signed [tna_pkg::EDGE_W-1:0]     e2_q [3];
	logic signed [tna_pkg::CROSS_W-1:0]    c_q [3];

	logic signed [tna_pkg::MOP_W-1:0]      ma, mb;
	logic signed [tna_pkg::PROD_W-1:0]     p_s1;
	logic signed [tna_pkg::PROD_W-1:0]     hold_q;
	logic [tna_pkg::CNT_W-1:0]             prev_step;
	tna_pkg::tna_sq_sel_t                  sq_issue, sq_take;
	logic signed [tna_pkg::SUM_W-1:0]      pext;
	logic [tna_pkg::SUM_W-1:0]             term;
	logic [tna_pkg::SUM_W-1:0]             acc_q;

	logic [tna_pkg::SUM_W-1:0]             sv_q;
	logic [tna_pkg::ROOT_W-1:0]            root_q;
	logic [tna_pkg::REM_W-1:0]             rem_q;
	logic [tna_pkg::REM_W+1:0]             rem_n, trial;
	logic [tna_pkg::ROOT_W-1:0]            len_w;
	logic                                  degen_w;

	logic signed [tna_pkg::CROSS_W-1:0]    c_sel;
	logic [tna_pkg::CROSS_W-1:0]           mag_w;
	logic [tna_pkg::ROOT_W-1:0]            drem_q;
	logic [tna_pkg::QUO_W-1:0]             nb_q, q_q;
	logic [tna_pkg::ROOT_W:0]              r2;
	logic [tna_pkg::QUO_W:0]               q_inc;
	logic [tna_pkg::QUO_W-1:0]             q_rnd;
	logic signed [tna_pkg::NORM_W-1:0]     norm_q [3];

	// store write and corner checks
	assign load_ok = ({1'b0, vert_index} < (tna_pkg::IDX_W + 1)'(tna_pkg::VERTEX_COUNT));
	assign status.is_face = (op == tna_pkg::OP_FACE);
	assign status.face_ok =
		({1'b0, corner_a} < (tna_pkg::IDX_W + 1)'(tna_pkg::VERTEX_COUNT)) &&
		({1'b0, corner_b} < (tna_pkg::IDX_W + 1)'(tna_pkg::VERTEX_COUNT)) &&
		({1'b0, corner_c} < (tna_pkg::IDX_W + 1)'(tna_pkg::VERTEX_COUNT));
	assign wr_en = cmd.accept && !status.is_face && load_ok;

	always_comb begin
		if (cmd.ld_v0) begin
			rd_addr = tna_pkg::ADDR_W'(corner_b_q);
		end else if (cmd.ld_v1) begin
			rd_addr = tna_pkg::ADDR_W'(corner_c_q);
		end else begin
			rd_addr = tna_pkg::ADDR_W'(corner_a);
		end
	end

	tna_ram #(
		.WIDTH (tna_pkg::VERT_W),
		.DEPTH (tna_pkg::VERTEX_COUNT)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tna_pkg::ADDR_W'(vert_index)),
		.wr_data ({coord_x, coord_y, coord_z}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign v2[0] = signed'(rd_data[3*tna_pkg::COORD_W-1 -: tna_pkg::COORD_W]);
	assign v2[1] = signed'(rd_data[2*tna_pkg::COORD_W-1 -: tna_pkg::COORD_W]);
	assign v2[2] = signed'(rd_data[tna_pkg::COORD_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			corner_b_q <= corner_b;
			corner_c_q <= corner_c;
		end
		if (cmd.ld_v0) begin
			v0_q <= v2;
		end
		if (cmd.ld_v1) begin
			v1_q <= v2;
		end
		if (cmd.ld_edge) begin
			for (int j = 0; j < 3; j++) begin
				e1_q[j] <= tna_pkg::EDGE_W'(v1_q[j]) - tna_pkg::EDGE_W'(v0_q[j]);
				e2_q[j] <= tna_pkg::EDGE_W'(v2[j]) - tna_pkg::EDGE_W'(v0_q[j]);
			end
		end
	end

	// shared multiplier: cross terms, then split squares of the cross components
	assign prev_step = cmd.step - 1'b1;
	assign sq_issue  = sq_map(cmd.step[3:0]);
	assign sq_take   = sq_map(prev_step[3:0]);

	always_comb begin
		ma = '0;
		mb = '0;
		if (cmd.cross_en) begin
			case (cmd.step[2:0])
				3'd0: begin ma = tna_pkg::MOP_W'(e1_q[1]); mb = tna_pkg::MOP_W'(e2_q[2]); end
				3'd1: begin ma = tna_pkg::MOP_W'(e1_q[2]); mb = tna_pkg::MOP_W'(e2_q[1]); end
				3'd2: begin ma = tna_pkg::MOP_W'(e1_q[2]); mb = tna_pkg::MOP_W'(e2_q[0]); end
				3'd3: begin ma = tna_pkg::MOP_W'(e1_q[0]); mb = tna_pkg::MOP_W'(e2_q[2]); end
				3'd4: begin ma = tna_pkg::MOP_W'(e1_q[0]); mb = tna_pkg::MOP_W'(e2_q[1]); end
				3'd5: begin ma = tna_pkg::MOP_W'(e1_q[1]); mb = tna_pkg::MOP_W'(e2_q[0]); end
				default: begin ma = '0; mb = '0; end
			endcase
		end else if (cmd.square_en) begin
			case (sq_issue.term)
				tna_pkg::TERM_HH: begin
					ma = tna_pkg::MOP_W'(signed'(
						c_q[sq_issue.comp][tna_pkg::CROSS_W-1:tna_pkg::LO_W]));
					mb = ma;
				end
				tna_pkg::TERM_LL: begin
					ma = signed'(tna_pkg::MOP_W'(c_q[sq_issue.comp][tna_pkg::LO_W-1:0]));
					mb = ma;
				end
				tna_pkg::TERM_HL: begin
					ma = tna_pkg::MOP_W'(signed'(
						c_q[sq_issue.comp][tna_pkg::CROSS_W-1:tna_pkg::LO_W]));
					mb = signed'(tna_pkg::MOP_W'(c_q[sq_issue.comp][tna_pkg::LO_W-1:0]));
				end
				default: begin ma = '0; mb = '0; end
			endcase
		end
	end

	assign pext = tna_pkg::SUM_W'(p_s1);

	always_comb begin
		case (sq_take.term)
			tna_pkg::TERM_HH: term = unsigned'(pext) << tna_pkg::HH_SHIFT;
			tna_pkg::TERM_HL: term = unsigned'(pext) << tna_pkg::HL_SHIFT;
			default:          term = unsigned'(pext);
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1 <= ma * mb;
		if (cmd.cross_en && cmd.step != '0) begin
			if (!prev_step[0]) begin
				hold_q <= p_s1;
			end else begin
				c_q[prev_step[2:1]] <= tna_pkg::CROSS_W'(hold_q - p_s1);
			end
		end
		if (cmd.square_en) begin
			if (cmd.step == '0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + term;
			end
		end
	end

	// square root, two bits of the sum per cycle
	assign rem_n   = {rem_q, sv_q[tna_pkg::SUM_W-1 -: 2]};
	assign trial   = (tna_pkg::REM_W + 2)'({root_q, 2'b01});
	assign degen_w = (root_q == '0);
	assign len_w   = degen_w ? tna_pkg::ROOT_W'(1) : root_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_en) begin
			if (cmd.step == '0) begin
				sv_q   <= acc_q;
				root_q <= '0;
				rem_q  <= '0;
			end else begin
				sv_q <= sv_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= tna_pkg::REM_W'(rem_n - trial);
					root_q <= {root_q[tna_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= tna_pkg::REM_W'(rem_n);
					root_q <= {root_q[tna_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// normal component: |c| * 2^31 / L, halved with round half up; the top part of the
	// numerator (|c| / 2) is already below L, so 32 quotient bits suffice
	assign c_sel = c_q[cmd.comp];
	assign mag_w = c_sel[tna_pkg::CROSS_W-1] ? tna_pkg::CROSS_W'(-c_sel) : c_sel;
	assign r2    = {drem_q, nb_q[tna_pkg::QUO_W-1]};
	assign q_inc = {1'b0, q_q} + 1'b1;
	assign q_rnd = q_inc[tna_pkg::QUO_W:1];

	always_ff @(posedge clk) begin
		if (cmd.div_en) begin
			if (cmd.step == '0) begin
				drem_q <= tna_pkg::ROOT_W'(mag_w >> 1);
				nb_q   <= {mag_w[0], (tna_pkg::QUO_W - 1)'(0)};
				q_q    <= '0;
			end else if (cmd.step == tna_pkg::DIV_LAST) begin
				norm_q[cmd.comp] <= c_sel[tna_pkg::CROSS_W-1] ?
					tna_pkg::NORM_W'(-q_rnd) : tna_pkg::NORM_W'(q_rnd);
			end else begin
				nb_q <= nb_q << 1;
				if (r2 >= {1'b0, len_w}) begin
					drem_q <= tna_pkg::ROOT_W'(r2 - {1'b0, len_w});
					q_q    <= {q_q[tna_pkg::QUO_W-2:0], 1'b1};
				end else begin
					drem_q <= tna_pkg::ROOT_W'(r2);
					q_q    <= {q_q[tna_pkg::QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			normal_x      <= norm_q[0];
			normal_y      <= norm_q[1];
			normal_z      <= norm_q[2];
			face_area_out <= tna_pkg::AREA_W'(root_q >> 1);
			degenerate    <= degen_w;
		end
	end

endmodule

`default_nettype wire

### hdl/triangle_normal_area.sv
// Face normal and area: a load request writes one vertex, 1 per cycle while no face is in
// progress. A face request goes through three store reads, 7 cross-product and 10 square
// steps on one multiplier, 53 root steps and 3 x 34 divide steps; no further request is
// taken until its result is loaded. A waiting result does not block loads.
// Reset clears the sequencer and the result valid; store contents are undefined until written.
// Depends on tna_pkg, tna_if, tna_ctrl, tna_datapath.
`default_nettype none

module triangle_normal_area (
	input  wire logic clk,
	input  wire logic arst_n,
	tna_item_if.sink     item,
	tna_result_if.source result
);

	tna_pkg::tna_cmd_t    cmd;
	tna_pkg::tna_status_t status;

	tna_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tna_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.op            (item.op),
		.vert_index    (item.vert_index),
		.coord_x       (item.coord_x),
		.coord_y       (item.coord_y),
		.coord_z       (item.coord_z),
		.corner_a      (item.corner_a),
		.corner_b      (item.corner_b),
		.corner_c      (item.corner_c),
		.normal_x      (result.normal_x),
		.normal_y      (result.normal_y),
		.normal_z      (result.normal_z),
		.face_area_out (result.face_area_out),
		.degenerate    (result.degenerate)
	);

endmodule

`default_nettype wire

### hdl/tna_checker.sv
// Port-level checks of triangle_normal_area, bound to the top level.
// Depends on assert_macros.svh and tna_pkg.
`default_nettype none
`include "assert_macros.svh"

module tna_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic                               in_op,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [tna_pkg::NORM_W-1:0]  normal_x,
	input wire logic signed [tna_pkg::NORM_W-1:0]  normal_y,
	input wire logic signed [tna_pkg::NORM_W-1:0]  normal_z,
	input wire logic [tna_pkg::AREA_W-1:0]         face_area_out,
	input wire logic                               degenerate
);

	// a stalled result keeps its payload
	`TNA_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(face_area_out))

	// zero-length face gives a zero normal and zero area
	`TNA_ASSERT(a_degen_zero, clk, arst_n, out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0 && face_area_out == '0)

	// a face request occupies the block; only faces with all corners in range do, so this check fails on others
	`TNA_ASSERT(a_face_busy, clk, arst_n, in_valid && in_ready && in_op == tna_pkg::OP_FACE |=> !in_ready)

	`TNA_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid)

endmodule

bind triangle_normal_area tna_checker u_tna_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.in_op         (item.op),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.normal_x      (result.normal_x),
	.normal_y      (result.normal_y),
	.normal_z      (result.normal_z),
	.face_area_out (result.face_area_out),
	.degenerate    (result.degenerate)
);

`default_nettype wire

### tb/triangle_normal_area_tb.sv
// Self-checking testbench of the triangle face normal and area block.
// Depends on tna_pkg, tna_if and triangle_normal_area.
`timescale 1ns / 1ps

module triangle_normal_area_tb;

	typedef struct {
		logic signed [tna_pkg::NORM_W-1:0] nx;
		logic signed [tna_pkg::NORM_W-1:0] ny;
		logic signed [tna_pkg::NORM_W-1:0] nz;
		logic [tna_pkg::AREA_W-1:0]        area;
		logic                              degen;
	} face_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	tna_item_if   item ();
	tna_result_if result ();

	triangle_normal_area uut (.clk(clk), .arst_n(arst_n), .item(item), .result(result));

	always #2 clk = ~clk;

	// shadow copy of the vertex store
	logic signed [tna_pkg::COORD_W-1:0] vx [tna_pkg::VERTEX_COUNT];
	logic signed [tna_pkg::COORD_W-1:0] vy [tna_pkg::VERTEX_COUNT];
	logic signed [tna_pkg::COORD_W-1:0] vz [tna_pkg::VERTEX_COUNT];
	bit                                 written [tna_pkg::VERTEX_COUNT];
	int                                 written_list [$];

	face_result_t pending_faces [$];
	int  errors = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_cycles = 0;

	function automatic logic [63:0] round_div(logic [127:0] num, logic [63:0] d);
		logic [127:0] q;
		q = num / d;
		return (q + 1) >> 1;
	endfunction

	function automatic face_result_t predict_face(int a, int b, int c);
		face_result_t r;
		longint e1 [3];
		longint e2 [3];
		longint cr [3];
		logic [127:0] s;
		logic [127:0] root;
		logic [127:0] bitv;
		logic [127:0] m;
		logic [63:0] len;
		logic [63:0] q;
		e1[0] = longint'(vx[b]) - longint'(vx[a]);
		e1[1] = longint'(vy[b]) - longint'(vy[a]);
		e1[2] = longint'(vz[b]) - longint'(vz[a]);
		e2[0] = longint'(vx[c]) - longint'(vx[a]);
		e2[1] = longint'(vy[c]) - longint'(vy[a]);
		e2[2] = longint'(vz[c]) - longint'(vz[a]);
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		s = 0;
		for (int j = 0; j < 3; j++) begin
			m = (cr[j] < 0) ? 128'(-cr[j]) : 128'(cr[j]);
			s += m * m;
		end
		// bitwise floor square root
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			bitv = root | (128'd1 << i);
			if (bitv * bitv <= s)
				root = bitv;
		end
		len = root[63:0];
		r.degen = (len == 0);
		if (r.degen)
			len = 1;
		r.area = tna_pkg::AREA_W'(len >> 1);
		for (int j = 0; j < 3; j++) begin
			m = (cr[j] < 0) ? 128'(-cr[j]) : 128'(cr[j]);
			q = round_div(m << 31, len);
			if (cr[j] < 0)
				q = -q;
			case (j)
				0: r.nx = q[31:0];
				1: r.ny = q[31:0];
				default: r.nz = q[31:0];
			endcase
		end
		return r;
	endfunction

	task automatic idle_sender();
		item.valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
	endtask

	// valid stays high into the next request; wait_drained drops it
	task automatic send_request(tna_pkg::tna_op_t op, int idx, int x, int y, int z, int a,
			int b, int c);
		if ($urandom_range(99) < send_idle_pct) begin
			idle_sender();
			@(negedge clk);
		end
		item.valid      <= 1'b1;
		item.op         <= op;
		item.vert_index <= tna_pkg::IDX_W'(idx);
		item.coord_x    <= tna_pkg::COORD_W'(x);
		item.coord_y    <= tna_pkg::COORD_W'(y);
		item.coord_z    <= tna_pkg::COORD_W'(z);
		item.corner_a   <= tna_pkg::IDX_W'(a);
		item.corner_b   <= tna_pkg::IDX_W'(b);
		item.corner_c   <= tna_pkg::IDX_W'(c);
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		if (op == tna_pkg::OP_LOAD) begin
			if (idx < tna_pkg::VERTEX_COUNT) begin
				vx[idx] = tna_pkg::COORD_W'(x);
				vy[idx] = tna_pkg::COORD_W'(y);
				vz[idx] = tna_pkg::COORD_W'(z);
				if (!written[idx])
					written_list = {written_list, idx};
				written[idx] = 1'b1;
			end
		end else if (a < tna_pkg::VERTEX_COUNT && b < tna_pkg::VERTEX_COUNT &&
				c < tna_pkg::VERTEX_COUNT) begin
			pending_faces = {pending_faces, predict_face(a, b, c)};
		end
		@(negedge clk);
	endtask

	task automatic load_vertex(int idx, int x, int y, int z);
		send_request(tna_pkg::OP_LOAD, idx, x, y, z, $urandom_range(4095),
			$urandom_range(4095), $urandom_range(4095));
	endtask

	task automatic face(int a, int b, int c);
		send_request(tna_pkg::OP_FACE, $urandom_range(4095), $urandom, $urandom, $urandom,
			a, b, c);
	endtask

	function automatic int rand_coord(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic int pick_written();
		return written_list[$urandom_range(written_list.size() - 1)];
	endfunction

	task automatic wait_drained();
		item.valid <= 1'b0;
		while (pending_faces.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		load_vertex(0, 0, 0, 0);
		load_vertex(1, 24'sh7fffff, 0, 0);
		load_vertex(2, 0, 24'sh7fffff, 0);
		load_vertex(4095, -8388608, -8388608, -8388608);
		load_vertex(4094, 8388607, 8388607, -8388608);
		load_vertex(3, 65536, 65536, 65536);
		load_vertex(5, 1, 0, 0);
		load_vertex(6, 0, 1, 0);
		face(0, 1, 2);
		face(2, 1, 0);
		face(0, 0, 0);           // all corners equal: zero length
		face(0, 3, 3);           // collinear
		face(4095, 4094, 1);     // largest edges
		face(4094, 4095, 2);
		face(0, 5, 6);           // smallest nonzero cross product (area output 0)
		face(1, 2, 4095);
		face(3, 4095, 0);
		wait_drained();
	endtask

	task automatic random_phase(int n, int sidle, int rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		for (int i = 0; i < n; i++) begin
			int sel;
			int span;
			sel = $urandom_range(99);
			span = ($urandom_range(3) == 0) ? 8388607 : $urandom_range(1 << 18);
			if (sel < 40)
				load_vertex($urandom_range(4095), rand_coord(span), rand_coord(span),
					rand_coord(span));
			else if (sel < 45)
				face(pick_written(), pick_written(), pick_written());
			else if (sel < 50) begin
				int a;
				a = pick_written();
				face(a, a, pick_written());
			end else
				face(pick_written(), pick_written(), pick_written());
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 1200;
		for (int i = 0; i < 6; i++)
			face(pick_written(), pick_written(), pick_written());
		for (int i = 0; i < 4; i++)
			load_vertex($urandom_range(4095), rand_coord(8388607), rand_coord(8388607),
				rand_coord(8388607));
		wait_drained();
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result.ready <= 1'b0;
				hold_cycles--;
			end else begin
				result.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (pending_faces.size() == 0) begin
				$display("%0t: unexpected result nx=%0d", $time, result.normal_x);
				errors++;
			end else begin
				face_result_t e;
				e = pending_faces.pop_front();
				if (result.normal_x !== e.nx || result.normal_y !== e.ny ||
						result.normal_z !== e.nz || result.face_area_out !== e.area ||
						result.degenerate !== e.degen) begin
					$display("%0t: expected n=(%0d,%0d,%0d) area=%0d degen=%0b",
						$time, e.nx, e.ny, e.nz, e.area, e.degen);
					$display("%0t: actual   n=(%0d,%0d,%0d) area=%0d degen=%0b",
						$time, result.normal_x, result.normal_y, result.normal_z,
						result.face_area_out, result.degenerate);
					errors++;
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("triangle_normal_area: mismatch");
		$finish;
	end

	initial begin
		item.valid = 1'b0;
		item.op = tna_pkg::OP_LOAD;
		item.vert_index = '0;
		item.coord_x = '0;
		item.coord_y = '0;
		item.coord_z = '0;
		item.corner_a = '0;
		item.corner_b = '0;
		item.corner_c = '0;
		// falling reset edge before the first clock edge
		#1 arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		random_phase(250, 0, 0);
		random_phase(250, 52, 0);
		random_phase(250, 0, 52);
		test_backpressure();
		random_phase(250, 38, 38);
		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("triangle_normal_area: match");
		else
			$display("triangle_normal_area: mismatch");
		$finish;
	end
endmodule
